>>> design/change_flag_update_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Change-flag update scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef CHANGE_FLAG_UPDATE_SCHEDULER_MACROS_SVH
`define CHANGE_FLAG_UPDATE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFUS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFUS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cfus_pkg.sv
// ----------------------------------------------------------------------------
// Change-flag update scheduler package
// Shared types and fixed widths for the scheduler modules.
// ----------------------------------------------------------------------------
package cfus_pkg;

	// Widths wide enough for the largest supported item and slot counts.
	localparam int IDX_MAX_W = 5;
	localparam int PTR_MAX_W = 5;

	typedef struct packed {
		logic                 hit;
		logic [IDX_MAX_W-1:0] index;
		logic [PTR_MAX_W-1:0] next_ptr;
	} pick_t;

endpackage

>>> design/cfus_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cfus_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/cfus_pick.sv
// ----------------------------------------------------------------------------
// Change-flag update scheduler grant logic
// Fixed-priority search over the priority items, then a search of the
// rotating slots at or after the slot pointer.
// ----------------------------------------------------------------------------
module cfus_pick #(
	parameter int PRIORITY_ITEMS = 3,
	parameter int ROTATING_SLOTS = 9
) (
	input  logic [PRIORITY_ITEMS+ROTATING_SLOTS-1:0] pending,
	input  logic [cfus_pkg::PTR_MAX_W-1:0]           ptr,
	output cfus_pkg::pick_t                          pick
);
	import cfus_pkg::*;

	logic                 prio_hit;
	logic [IDX_MAX_W-1:0] prio_idx;
	logic                 slot_hit;
	logic [PTR_MAX_W-1:0] slot_k;

	always_comb begin
		prio_hit = 1'b0;
		prio_idx = '0;
		for (int i = PRIORITY_ITEMS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				prio_hit = 1'b1;
				prio_idx = IDX_MAX_W'(i);
			end
		end
	end

	// Lowest pending slot number that is not below the pointer.
	always_comb begin
		slot_hit = 1'b0;
		slot_k   = '0;
		for (int k = ROTATING_SLOTS; k >= 1; k--) begin
			if (pending[PRIORITY_ITEMS-1+k] && (PTR_MAX_W'(k) >= ptr)) begin
				slot_hit = 1'b1;
				slot_k   = PTR_MAX_W'(k);
			end
		end
	end

	always_comb begin
		if (prio_hit) begin
			pick.hit      = 1'b1;
			pick.index    = prio_idx;
			pick.next_ptr = ptr;
		end else if (slot_hit) begin
			pick.hit      = 1'b1;
			pick.index    = IDX_MAX_W'(PRIORITY_ITEMS - 1) + IDX_MAX_W'(slot_k);
			pick.next_ptr = slot_k + PTR_MAX_W'(1);
		end else begin
			pick.hit      = 1'b0;
			pick.index    = '0;
			pick.next_ptr = PTR_MAX_W'(1);
		end
	end

endmodule

>>> design/change_flag_update_scheduler.sv
// ----------------------------------------------------------------------------
// Change-flag update scheduler
// Stores display values with pending flags and serves changed values to a
// poller, priority items first and then the rotating slots in turn.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_ready | func, item_index, new_value
//  output  | out_valid/out_ready | served, served_index, served_value
//
// For each request, the accept cycle issues the value memory read, and
// the following cycle consumes the registered read data. A new request
// is taken only once the request in flight has consumed its read data.
// After reset no memory entry is valid; an unwritten entry reads as zero.
// A poll is accepted only when the output register is free or drains in
// the same cycle, while updates are accepted regardless of a waiting result.
// ----------------------------------------------------------------------------
`include "change_flag_update_scheduler_macros.svh"

module change_flag_update_scheduler #(
	parameter int PRIORITY_ITEMS = 3,
	parameter int ROTATING_SLOTS = 9,
	parameter int VALUE_BITS     = 40
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             in_valid,
	output logic                                             in_ready,
	input  logic                                             func,
	input  logic [$clog2(PRIORITY_ITEMS+ROTATING_SLOTS)-1:0] item_index,
	input  logic [VALUE_BITS-1:0]                            new_value,
	output logic                                             out_valid,
	input  logic                                             out_ready,
	output logic                                             served,
	output logic [$clog2(PRIORITY_ITEMS+ROTATING_SLOTS)-1:0] served_index,
	output logic [VALUE_BITS-1:0]                            served_value
);
	import cfus_pkg::*;

	localparam int TOTAL = PRIORITY_ITEMS + ROTATING_SLOTS;
	localparam int IDX_W = $clog2(TOTAL);
	localparam int PTR_W = $clog2(ROTATING_SLOTS + 2);

	// Control state: pending flags, per-entry written bits and slot pointer.
	logic [TOTAL-1:0] pending_q;
	logic [TOTAL-1:0] written_q;
	logic [PTR_W-1:0] ptr_q;

	// Second stage of the request in flight.
	logic                  v_s1;
	logic                  func_s1;
	logic                  hit_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [VALUE_BITS-1:0] val_s1;

	logic                  accept;
	logic                  poll_accept;
	pick_t                 pick;
	logic [IDX_W-1:0]      rd_addr;
	logic [VALUE_BITS-1:0] rd_data;
	logic [VALUE_BITS-1:0] cur_value;
	logic                  idx_in_range;
	logic                  upd_write;

	// A poll needs the output register to be free by the time its result is loaded.
	assign in_ready    = !v_s1 && (!func || !out_valid || out_ready);
	assign accept      = in_valid && in_ready;
	assign poll_accept = accept && func;

	cfus_pick #(
		.PRIORITY_ITEMS (PRIORITY_ITEMS),
		.ROTATING_SLOTS (ROTATING_SLOTS)
	) u_pick (
		.pending (pending_q),
		.ptr     (PTR_MAX_W'(ptr_q)),
		.pick    (pick)
	);

	assign rd_addr = func ? pick.index[IDX_W-1:0] : item_index;

	cfus_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TOTAL)
	) u_values (
		.clk   (clk),
		.we    (upd_write),
		.waddr (idx_s1),
		.wdata (val_s1),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// An entry never written since reset reads as zero through the written bits.
	assign idx_in_range = ({1'b0, idx_s1} < (IDX_W + 1)'(TOTAL));
	assign cur_value    = (idx_in_range && written_q[idx_s1]) ? rd_data : '0;

	// An update stores only a changed value; only then is its flag raised.
	assign upd_write = v_s1 && !func_s1 && idx_in_range && (cur_value != val_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			hit_s1  <= pick.hit;
			idx_s1  <= rd_addr;
			val_s1  <= new_value;
		end
	end

	// The grant is decided in the accept cycle, so flags and pointer move
	// there; the update path sets its flag in the cycle after. The two never
	// overlap because only one request is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			written_q <= '0;
			ptr_q     <= PTR_W'(1);
		end else begin
			if (poll_accept) begin
				ptr_q <= pick.next_ptr[PTR_W-1:0];
				if (pick.hit) begin
					pending_q[pick.index[IDX_W-1:0]] <= 1'b0;
				end
			end
			if (upd_write) begin
				pending_q[idx_s1] <= 1'b1;
				written_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Output register: loaded by a poll from its second stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (v_s1 && func_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && func_s1) begin
			served       <= hit_s1;
			served_index <= hit_s1 ? idx_s1 : '0;
			served_value <= hit_s1 ? cur_value : '0;
		end
	end

	`CFUS_ASSERT_NOW(a_one_in_flight, v_s1, !in_ready, "request accepted while one is in flight")
	`CFUS_ASSERT_NEXT(a_poll_result, v_s1 && func_s1, out_valid, "poll produced no result")
	`CFUS_ASSERT_NOW(a_miss_zero, out_valid && !served,
		(served_index == '0) && (served_value == '0), "empty poll result not zero")
	`CFUS_ASSERT_NOW(a_ptr_range, 1'b1,
		(ptr_q >= PTR_W'(1)) && (ptr_q <= PTR_W'(ROTATING_SLOTS + 1)),
		"slot pointer out of range")
	`CFUS_ASSERT_NEXT(a_update_flag, upd_write, pending_q[$past(idx_s1)],
		"changed update left its flag clear")

endmodule
